// ----- rtl/step_bound_reduction_core_macros.svh -----
// Assertion macros shared by the step bound reduction modules.
`ifndef STEP_BOUND_REDUCTION_CORE_MACROS_SVH
`define STEP_BOUND_REDUCTION_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define SBR_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SBR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sbr_pkg.sv -----
// Shared constants and controller/datapath signal groups for the step bound reduction core.
package sbr_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    typedef struct packed {
        logic load;
        logic setup;
        logic step;
        logic ratio;
        logic update;
    } sbr_cmd_t;

    typedef struct packed {
        logic dir_zero;
        logic last;
        logic out_busy;
    } sbr_status_t;

endpackage

// ----- rtl/sbr_in_if.sv -----
// Element input channel: valid/ready handshake with one vector element as payload.
interface sbr_in_if #(
    parameter int DATA_WIDTH = sbr_pkg::DATA_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] point_value;
    logic signed [DATA_WIDTH-1:0] lower_bound;
    logic signed [DATA_WIDTH-1:0] upper_bound;
    logic signed [DATA_WIDTH-1:0] direction;
    logic                         last_element;

    modport source (
        output valid, point_value, lower_bound, upper_bound, direction, last_element,
        input  ready
    );

    modport sink (
        input  valid, point_value, lower_bound, upper_bound, direction, last_element,
        output ready
    );
endinterface

// ----- rtl/sbr_out_if.sv -----
// Result output channel: valid/ready handshake carrying the three step bounds.
interface sbr_out_if #(
    parameter int DATA_WIDTH = sbr_pkg::DATA_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] nearest_bound_step;
    logic signed [DATA_WIDTH-1:0] wolfe_step;
    logic signed [DATA_WIDTH-1:0] farthest_bound_step;

    modport source (
        output valid, nearest_bound_step, wolfe_step, farthest_bound_step,
        input  ready
    );

    modport sink (
        input  valid, nearest_bound_step, wolfe_step, farthest_bound_step,
        output ready
    );
endinterface

// ----- rtl/step_bound_reduction_core.sv -----
// Top level of the step bound reduction core: controller and datapath.
// Takes one vector element per transaction and forms the step ratio to the bound that the
// direction points at, (upper - point)/direction or (lower - point)/direction, in signed
// fixed point with FRAC_BITS fraction bits, saturated to the data range; a zero direction is
// skipped. The minimum, Wolfe minimum and maximum ratios are kept and, on the element marked
// last, sent as one result transaction and restored to their start values (largest positive,
// largest positive, zero). An element passes through accept, divider setup, DATA_WIDTH + 1
// radix-2 quotient iterations, ratio saturation and the update; an element with zero
// direction goes from divider setup straight to the update. A finished result
// waits in the output register while the next elements are processed; only a second last
// element stalls until it has been taken.
module step_bound_reduction_core #(
    parameter int DATA_WIDTH = sbr_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = sbr_pkg::FRAC_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    sbr_in_if.sink    elem,
    sbr_out_if.source result
);
    import sbr_pkg::*;

    sbr_cmd_t    cmd;
    sbr_status_t status;
    logic        elem_ready;

    assign elem.ready = elem_ready;

    sbr_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .elem_valid (elem.valid),
        .elem_ready (elem_ready),
        .status     (status),
        .cmd        (cmd)
    );

    sbr_dp #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .point_value  (elem.point_value),
        .lower_bound  (elem.lower_bound),
        .upper_bound  (elem.upper_bound),
        .direction    (elem.direction),
        .last_element (elem.last_element),
        .result       (result)
    );
endmodule

// ----- rtl/sbr_ctrl.sv -----
// Sequencer for the step bound reduction: accept, divider setup, iterations, ratio, update.
`include "step_bound_reduction_core_macros.svh"

module sbr_ctrl #(
    parameter int DATA_WIDTH = sbr_pkg::DATA_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                elem_valid,
    output logic                elem_ready,
    input  sbr_pkg::sbr_status_t status,
    output sbr_pkg::sbr_cmd_t    cmd
);
    import sbr_pkg::*;

    localparam int ITER = DATA_WIDTH + 1;
    localparam int CW   = $clog2(ITER);
    localparam logic [CW-1:0] CNT_LAST = CW'(ITER - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_DIV,
        S_RATIO,
        S_UPDATE
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          emit_stall;

    assign emit_stall = status.last && status.out_busy;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (elem_valid)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cnt_next   = '0;
                state_next = status.dir_zero ? S_UPDATE : S_DIV;
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_RATIO;
                end
            end
            S_RATIO:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (!emit_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign elem_ready = (state_reg == S_IDLE);
    assign cmd.load   = elem_ready && elem_valid;
    assign cmd.setup  = (state_reg == S_SETUP);
    assign cmd.step   = (state_reg == S_DIV);
    assign cmd.ratio  = (state_reg == S_RATIO);
    assign cmd.update = (state_reg == S_UPDATE) && !emit_stall;

    `SBR_ASSERT(a_cmd_onehot, 1'b1, $onehot0(cmd), "more than one datapath command active")
    `SBR_ASSERT(a_emit_free, cmd.update && status.last, !status.out_busy, "result overwritten")
    `SBR_ASSERT_NEXT(a_div_follows, cmd.setup && !status.dir_zero, cmd.step,
                     "divider did not start after setup")
endmodule

// ----- rtl/sbr_dp.sv -----
// Datapath: element registers, radix-2 restoring divider, saturation and running bounds.
`include "step_bound_reduction_core_macros.svh"

module sbr_dp #(
    parameter int DATA_WIDTH = sbr_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = sbr_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sbr_pkg::sbr_cmd_t            cmd,
    output sbr_pkg::sbr_status_t         status,
    input  logic signed [DATA_WIDTH-1:0] point_value,
    input  logic signed [DATA_WIDTH-1:0] lower_bound,
    input  logic signed [DATA_WIDTH-1:0] upper_bound,
    input  logic signed [DATA_WIDTH-1:0] direction,
    input  logic                         last_element,
    sbr_out_if.source                    result
);
    import sbr_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int NW = DW + 1 + FRAC_BITS;
    localparam logic [DW:0] DSIGN_Q  = (DW + 1)'(1) << (DW - 1);
    localparam logic [DW:0] MAXPOS_Q = DSIGN_Q - 1'b1;
    localparam logic signed [DW-1:0] MAXPOS = {1'b0, {(DW - 1){1'b1}}};

    // captured element
    logic signed [DW-1:0] x_reg, lo_reg, hi_reg, d_reg;
    logic                 last_reg;

    // divider
    logic [DW-1:0] rem_reg;
    logic [DW:0]   low_reg;
    logic [DW:0]   quo_reg;
    logic [DW-1:0] dmag_reg;
    logic          neg_reg;
    logic          ovf_reg;

    logic signed [DW-1:0] t_reg;
    logic signed [DW-1:0] min_reg, wolfe_reg, max_reg;
    logic signed [DW-1:0] nbs_reg, wolfe_out_reg, fbs_reg;
    logic                 out_valid_reg;

    // setup
    logic [DW-1:0] bnd;
    logic [DW:0]   diff;
    logic [DW:0]   nmag;
    logic [DW-1:0] dmag;
    logic [NW-1:0] numer;
    logic [NW-1:0] top;
    logic          ovf;

    assign bnd   = d_reg[DW-1] ? lo_reg : hi_reg;
    assign diff  = {bnd[DW-1], bnd} - {x_reg[DW-1], x_reg};
    assign nmag  = diff[DW] ? (~diff + 1'b1) : diff;
    assign dmag  = d_reg[DW-1] ? (~d_reg + 1'b1) : d_reg;
    assign numer = NW'(nmag) << FRAC_BITS;
    assign top   = numer >> (DW + 1);
    assign ovf   = (top >= NW'(dmag));

    // one quotient bit
    logic [DW:0] trial;
    logic [DW:0] trial_sub;
    logic        q_bit;

    assign trial     = {rem_reg, low_reg[DW]};
    assign trial_sub = trial - {1'b0, dmag_reg};
    assign q_bit     = (trial >= {1'b0, dmag_reg});

    // saturated signed ratio
    logic [DW:0]   neg_mag;
    logic [DW:0]   neg_val;
    logic [DW-1:0] t_val;

    assign neg_mag = (ovf_reg || (quo_reg > DSIGN_Q)) ? DSIGN_Q : quo_reg;
    assign neg_val = ~neg_mag + 1'b1;

    always_comb
    begin
        if (neg_reg)
        begin
            t_val = neg_val[DW-1:0];
        end
        else if (ovf_reg || (quo_reg > MAXPOS_Q))
        begin
            t_val = MAXPOS_Q[DW-1:0];
        end
        else
        begin
            t_val = quo_reg[DW-1:0];
        end
    end

    // running bounds
    logic                 dir_zero;
    logic signed [DW-1:0] min_new, wolfe_new, max_new;
    logic                 min_pos;

    assign dir_zero = (d_reg == '0);

    always_comb
    begin
        min_new   = min_reg;
        wolfe_new = wolfe_reg;
        max_new   = max_reg;
        min_pos   = 1'b0;
        if (!dir_zero)
        begin
            if (t_reg < min_reg)
            begin
                min_new = t_reg;
            end
            min_pos = !min_new[DW-1] && (min_new != '0);
            if (min_pos && (t_reg < wolfe_reg))
            begin
                wolfe_new = t_reg;
            end
            if (t_reg > max_reg)
            begin
                max_new = t_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg    <= point_value;
            lo_reg   <= lower_bound;
            hi_reg   <= upper_bound;
            d_reg    <= direction;
            last_reg <= last_element;
        end
        if (cmd.setup)
        begin
            rem_reg  <= top[DW-1:0];
            low_reg  <= numer[DW:0];
            quo_reg  <= '0;
            dmag_reg <= dmag;
            neg_reg  <= diff[DW] ^ d_reg[DW-1];
            ovf_reg  <= ovf;
        end
        if (cmd.step)
        begin
            rem_reg <= q_bit ? trial_sub[DW-1:0] : trial[DW-1:0];
            low_reg <= {low_reg[DW-1:0], 1'b0};
            quo_reg <= {quo_reg[DW-1:0], q_bit};
        end
        if (cmd.ratio)
        begin
            t_reg <= t_val;
        end
        if (cmd.update && last_reg)
        begin
            nbs_reg       <= min_new;
            wolfe_out_reg <= wolfe_new;
            fbs_reg       <= max_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg       <= MAXPOS;
            wolfe_reg     <= MAXPOS;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.update)
            begin
                if (last_reg)
                begin
                    min_reg   <= MAXPOS;
                    wolfe_reg <= MAXPOS;
                    max_reg   <= '0;
                end
                else
                begin
                    min_reg   <= min_new;
                    wolfe_reg <= wolfe_new;
                    max_reg   <= max_new;
                end
            end
            if (cmd.update && last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid               = out_valid_reg;
    assign result.nearest_bound_step  = nbs_reg;
    assign result.wolfe_step          = wolfe_out_reg;
    assign result.farthest_bound_step = fbs_reg;

    assign status.dir_zero = dir_zero;
    assign status.last     = last_reg;
    assign status.out_busy = out_valid_reg && !result.ready;

    `SBR_ASSERT(a_max_nonneg, 1'b1, !max_reg[DW-1], "running maximum went negative")
    `SBR_ASSERT(a_min_le_wolfe, 1'b1, min_reg <= wolfe_reg, "Wolfe minimum below running minimum")
    `SBR_ASSERT(a_valid_cause, $rose(out_valid_reg), $past(cmd.update) && $past(last_reg),
                "result raised without a last-element update")
endmodule
